// ===== rtl/core/cs_pkg.sv =====
// Shared types and widths for the cosine similarity block.
`timescale 1ns / 1ps
`default_nettype none
package cs_pkg;

    // accumulator and derived datapath widths
    localparam int ACC_W  = 48;
    localparam int PROD_W = 2 * ACC_W;       // norm product, squared dot
    localparam int Q_W    = 16;              // quotient incl. the value 32768
    localparam int T_W    = PROD_W + Q_W;    // q * P
    localparam int SQ_W   = PROD_W + 2 * Q_W + 2; // q^2 * P and trial sums
    localparam int CNT_W  = 17;
    localparam int QUEUE_DEPTH = 2;

    // one finished vector pair, handed from front to back
    typedef struct packed {
        logic [ACC_W-1:0] dot;      // signed dot product
        logic [ACC_W-1:0] norm_a;
        logic [ACC_W-1:0] norm_b;
        logic             too_long;
    } cs_job_t;

endpackage
`default_nettype wire

// ===== rtl/core/cs_queue.sv =====
// Small register queue between the accumulate front and the root/divide back.
`timescale 1ns / 1ps
`default_nettype none
module cs_queue import cs_pkg::*; (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         push,
    input  cs_job_t     push_job,
    input  wire         pop,
    output cs_job_t     head_job,
    output logic        not_empty,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cs_job_t                 slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] count_reg;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    assign head_job  = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;
endmodule
`default_nettype wire

// ===== rtl/core/cs_front.sv =====
// Front: takes element pairs, squares and multiplies, accumulates the sums.
`timescale 1ns / 1ps
`default_nettype none
module cs_front import cs_pkg::*; #(
    parameter int MAX_LEN = 4096
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [15:0] elem_a,
    input  wire  [15:0] elem_b,
    input  wire         last,
    input  wire  [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
    output logic        push,
    output cs_job_t     push_job
);
    localparam int CW = $clog2(QUEUE_DEPTH+1) + 1;

    logic             accept;
    logic [CNT_W-1:0] cnt_reg;
    logic             exceed_reg;
    logic             use_pair;

    // product stage
    logic             p_valid_reg, p_last_reg, p_use_reg, p_tl_reg;
    logic [31:0]      p_ab_reg, p_aa_reg, p_bb_reg;

    // sums
    logic [ACC_W-1:0] dot_reg, na_reg, nb_reg;
    logic [ACC_W-1:0] dot_next, na_next, nb_next;

    // a last beat in flight still needs a queue slot
    assign in_ready = (CW'(q_count) + CW'(p_valid_reg & p_last_reg)) < CW'(QUEUE_DEPTH);
    assign accept   = in_valid & in_ready;
    assign use_pair = cnt_reg < CNT_W'(MAX_LEN);

    // length tracking and products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            exceed_reg  <= 1'b0;
            p_valid_reg <= 1'b0;
            p_last_reg  <= 1'b0;
        end else begin
            p_valid_reg <= accept;
            p_last_reg  <= accept & last;
            if (accept) begin
                if (last) begin
                    cnt_reg    <= '0;
                    exceed_reg <= 1'b0;
                end else if (use_pair) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end else begin
                    exceed_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_ab_reg  <= 32'($signed(elem_a) * $signed(elem_b));
            p_aa_reg  <= 32'($signed(elem_a) * $signed(elem_a));
            p_bb_reg  <= 32'($signed(elem_b) * $signed(elem_b));
            p_use_reg <= use_pair;
            p_tl_reg  <= exceed_reg | ~use_pair;
        end
    end

    // accumulate
    always_comb begin
        dot_next = dot_reg;
        na_next  = na_reg;
        nb_next  = nb_reg;
        if (p_use_reg) begin
            dot_next = dot_reg + {{(ACC_W-32){p_ab_reg[31]}}, p_ab_reg};
            na_next  = na_reg + ACC_W'(p_aa_reg);
            nb_next  = nb_reg + ACC_W'(p_bb_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
        end else if (p_valid_reg) begin
            if (p_last_reg) begin
                dot_reg <= '0;
                na_reg  <= '0;
                nb_reg  <= '0;
            end else begin
                dot_reg <= dot_next;
                na_reg  <= na_next;
                nb_reg  <= nb_next;
            end
        end
    end

    assign push              = p_valid_reg & p_last_reg;
    assign push_job.dot      = dot_next;
    assign push_job.norm_a   = na_next;
    assign push_job.norm_b   = nb_next;
    assign push_job.too_long = p_tl_reg;
endmodule
`default_nettype wire

// ===== rtl/core/cs_back.sv =====
// Back: shift-add products, then bitwise search for 32768*|dot|/sqrt(na*nb).
`timescale 1ns / 1ps
`default_nettype none
module cs_back import cs_pkg::*; (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         job_valid,
    input  cs_job_t     job,
    output logic        pop,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [15:0] similarity,
    output logic        zero_norm,
    output logic        too_long
);
    typedef enum logic [2:0] {S_IDLE, S_MUL, S_TRY, S_CMP, S_DONE} state_t;

    localparam int MC_W = $clog2(ACC_W);

    state_t             state_reg;
    logic [MC_W-1:0]    mcnt_reg;
    logic [PROD_W-1:0]  mc_p_reg, mc_d_reg, p_reg, d_reg;
    logic [ACC_W-1:0]   mp_p_reg, mp_d_reg;
    logic [SQ_W-1:0]    s_reg, trial_reg, trial_next, d_scaled;
    logic [T_W-1:0]     t_reg;
    logic [3:0]         k_reg;
    logic [Q_W-1:0]     q_reg;
    logic               neg_reg, zn_reg, tl_reg;
    logic [ACC_W-1:0]   mag;
    logic               job_zero;
    logic [Q_W-1:0]     sim_next;

    logic               out_valid_reg, zn_out_reg, tl_out_reg;
    logic [15:0]        sim_out_reg;

    assign mag      = job.dot[ACC_W-1] ? (~job.dot + 1'b1) : job.dot;
    assign job_zero = (job.norm_a == '0) || (job.norm_b == '0);
    assign pop      = (state_reg == S_IDLE) && job_valid;

    // trial square: (q + 2^k)^2 P = S + 2^(k+1) qP + 2^(2k) P
    assign trial_next = s_reg + (SQ_W'(t_reg) << ({1'b0, k_reg} + 5'd1))
                              + (SQ_W'(p_reg) << {k_reg, 1'b0});
    assign d_scaled   = SQ_W'({d_reg, 30'b0});

    always_comb begin
        if (neg_reg)
            sim_next = ~q_reg + 1'b1;
        else if (q_reg[Q_W-1])
            sim_next = 16'h7FFF;
        else
            sim_next = q_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            // S_DONE reloads the output register itself
            if (out_valid_reg && out_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        neg_reg  <= job.dot[ACC_W-1];
                        zn_reg   <= job_zero;
                        tl_reg   <= job.too_long;
                        q_reg    <= '0;
                        mc_p_reg <= PROD_W'(job.norm_a);
                        mp_p_reg <= job.norm_b;
                        mc_d_reg <= PROD_W'(mag);
                        mp_d_reg <= mag;
                        p_reg    <= '0;
                        d_reg    <= '0;
                        mcnt_reg <= '0;
                        state_reg <= job_zero ? S_DONE : S_MUL;
                    end
                end
                // one multiplier bit per cycle for both products
                S_MUL: begin
                    if (mp_p_reg[0]) p_reg <= p_reg + mc_p_reg;
                    if (mp_d_reg[0]) d_reg <= d_reg + mc_d_reg;
                    mc_p_reg <= mc_p_reg << 1;
                    mc_d_reg <= mc_d_reg << 1;
                    mp_p_reg <= mp_p_reg >> 1;
                    mp_d_reg <= mp_d_reg >> 1;
                    mcnt_reg <= mcnt_reg + 1'b1;
                    if (mcnt_reg == MC_W'(ACC_W-1)) begin
                        s_reg     <= '0;
                        t_reg     <= '0;
                        k_reg     <= 4'(Q_W-1);
                        state_reg <= S_TRY;
                    end
                end
                S_TRY: begin
                    trial_reg <= trial_next;
                    state_reg <= S_CMP;
                end
                // keep the bit if the trial square does not exceed the target
                S_CMP: begin
                    if (trial_reg <= d_scaled) begin
                        s_reg <= trial_reg;
                        t_reg <= t_reg + (T_W'(p_reg) << k_reg);
                        q_reg <= q_reg | (Q_W'(1) << k_reg);
                    end
                    if (k_reg == '0)
                        state_reg <= S_DONE;
                    else begin
                        k_reg     <= k_reg - 1'b1;
                        state_reg <= S_TRY;
                    end
                end
                S_DONE: begin
                    if (!out_valid_reg || out_ready) begin
                        out_valid_reg <= 1'b1;
                        sim_out_reg   <= zn_reg ? 16'h0000 : sim_next;
                        zn_out_reg    <= zn_reg;
                        tl_out_reg    <= tl_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign similarity = sim_out_reg;
    assign zero_norm  = zn_out_reg;
    assign too_long   = tl_out_reg;
endmodule
`default_nettype wire

// ===== rtl/core/cosine_similarity.sv =====
// Top level of the streaming cosine similarity block.
//
//  channel  | dir | tdata                             | tuser / tlast
//  s_axis   | in  | [15:0] elem_a, [31:16] elem_b     | tlast = last
//  m_axis   | out | [15:0] similarity                 | tuser [0] zero_norm, [1] too_long
//
// One element pair is taken every cycle while the queue has room; accumulation
// runs two stages deep. Each finished vector pair goes through the back end in
// order: a load, shift-add steps for both wide products, a trial and a compare
// step per quotient bit, and a load of the output register, which waits on tready.
// A two-entry queue lets the front keep streaming while the back works; the
// front stalls when the queue, counting a last beat still in flight, is full. Reset is synchronous, active low.
`timescale 1ns / 1ps
`default_nettype none
module cosine_similarity import cs_pkg::*; #(
    parameter int MAX_LEN = 4096
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [15:0] elem_a, [31:16] elem_b
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] similarity
    output logic [1:0]  m_axis_tuser    // [0] zero_norm, [1] too_long
);
    logic        push, pop, q_valid;
    cs_job_t     push_job, head_job;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
    logic        zn, tl;

    cs_front #(.MAX_LEN(MAX_LEN)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .elem_a   (s_axis_tdata[15:0]),
        .elem_b   (s_axis_tdata[31:16]),
        .last     (s_axis_tlast),
        .q_count  (q_count),
        .push     (push),
        .push_job (push_job)
    );

    cs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head_job  (head_job),
        .not_empty (q_valid),
        .count     (q_count)
    );

    cs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (q_valid),
        .job        (head_job),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .similarity (m_axis_tdata),
        .zero_norm  (zn),
        .too_long   (tl)
    );

    assign m_axis_tuser = {tl, zn};
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the cosine similarity block.
`timescale 1ns / 1ps
module tb;
    import cs_pkg::*;

    localparam int VEC_MAX = 4096;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic signed [15:0] similarity;
        logic               zero_norm;
        logic               too_long;
    } sim_result_t;

    // running sums for one vector pair and the results still owed by the block
    class similarity_board;
        longint      dot_acc;
        longint      sq_a_acc;
        longint      sq_b_acc;
        int          pairs;
        bit          overflowed;
        sim_result_t owed[$];
        int          errors;

        function void clear();
            dot_acc = 0;
            sq_a_acc = 0;
            sq_b_acc = 0;
            pairs = 0;
            overflowed = 0;
        endfunction

        // exact quotient: largest q with q*q*na*nb <= (32768*|dot|)^2
        function sim_result_t finish_vector();
            sim_result_t r;
            logic [127:0] nprod, target, lhs, wa, wb;
            longint mag;
            longint lo, hi, q;
            r.zero_norm = (sq_a_acc == 0) || (sq_b_acc == 0);
            r.too_long = overflowed;
            r.similarity = '0;
            if (!r.zero_norm) begin
                mag = dot_acc < 0 ? -dot_acc : dot_acc;
                wa = sq_a_acc;
                wb = sq_b_acc;
                nprod = wa * wb;
                target = mag;
                target = target << 15;
                target = target * target;
                lo = 0;
                hi = 32768;
                while (lo < hi) begin
                    q = (lo + hi + 1) >> 1;
                    lhs = q * q;
                    lhs = lhs * nprod;
                    if (lhs <= target) lo = q;
                    else hi = q - 1;
                end
                if (dot_acc < 0) r.similarity = 16'(-lo);
                else r.similarity = lo > 32767 ? 16'sd32767 : 16'(lo);
            end
            return r;
        endfunction

        function void note_pair(logic signed [15:0] a, logic signed [15:0] b, bit last);
            sim_result_t res;
            if (pairs < VEC_MAX) begin
                dot_acc += longint'(a) * longint'(b);
                sq_a_acc += longint'(a) * longint'(a);
                sq_b_acc += longint'(b) * longint'(b);
                pairs++;
            end else begin
                overflowed = 1;
            end
            if (last) begin
                res = finish_vector();
                owed = {owed, res};
                clear();
            end
        endfunction

        function void check_result(logic signed [15:0] sim, logic zn, logic tl);
            sim_result_t e;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat: sim=%0d zn=%0b tl=%0b", sim, zn, tl);
                return;
            end
            e = owed.pop_front();
            if (e.similarity !== sim || e.zero_norm !== zn || e.too_long !== tl) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp sim=%0d zn=%0b tl=%0b got sim=%0d zn=%0b tl=%0b",
                             e.similarity, e.zero_norm, e.too_long, sim, zn, tl);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [15:0] elem_a, [31:16] elem_b
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] similarity
    logic [1:0]  m_axis_tuser;   // [0] zero_norm, [1] too_long

    cosine_similarity #(.MAX_LEN(VEC_MAX)) dut (.*);

    similarity_board board;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  quiet_cycles;
    bit  timed_out;

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // result side: check accepted beats, random backpressure
    initial begin
        m_axis_tready = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT && !timed_out) begin
            timed_out <= 1;
            $display("tb: errors");
            $finish;
        end
    end

    task automatic send_pair(logic [15:0] a, logic [15:0] b, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {b, a};
        s_axis_tlast <= last;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_pair(a, b, last);
    endtask

    function automatic logic [15:0] pick_elem();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // one vector pair; style picks how b relates to a
    task automatic send_vector(int len, int style);
        logic [15:0] a, b;
        for (int i = 0; i < len; i++) begin
            a = pick_elem();
            case (style)
                1: b = a;
                2: b = -a;
                3: b = a + 16'($urandom_range(7)) - 16'd3;
                4: begin a = 0; b = pick_elem(); end
                default: b = pick_elem();
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.owed.size() != 0) @(posedge aclk);
    endtask

    task automatic random_vectors(int pairs_wanted);
        int sent;
        int len;
        sent = 0;
        while (sent < pairs_wanted) begin
            len = $urandom_range(3) == 0 ? $urandom_range(40, 1) : $urandom_range(8, 1);
            send_vector(len, $urandom_range(5));
            sent += len;
        end
    endtask

    initial begin
        board = new();
        board.clear();
        board.errors = 0;
        aresetn = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tlast = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        quiet_cycles = 0;
        timed_out = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, full-scale match, opposite, zero norms, single pair
        send_pair(16'h8000, 16'h8000, 1);
        send_pair(16'h7fff, 16'h8000, 0);
        send_pair(16'h7fff, 16'h8000, 1);
        send_pair(16'h0000, 16'h1234, 1);
        send_pair(16'h4321, 16'h0000, 1);
        send_pair(16'h0000, 16'h0000, 1);
        send_pair(16'h0001, 16'h0001, 0);
        send_pair(16'hffff, 16'h0001, 1);
        send_pair(16'h0003, 16'h0004, 0);
        send_pair(16'h0004, 16'hfffd, 1);
        send_vector(4, 1);
        send_vector(4, 2);
        send_vector(3, 4);
        drain();

        send_idle_pct = 36;
        recv_idle_pct = 55;
        random_vectors(500);
        // sender holds off until the block has caught up
        drain();
        send_idle_pct = 55;
        recv_idle_pct = 36;
        random_vectors(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_vectors(450);
        drain();
        repeat (300) @(posedge aclk);

        if (board.errors == 0 && board.owed.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

// ===== cosine_similarity.f =====
rtl/core/cs_pkg.sv
rtl/core/cs_queue.sv
rtl/core/cs_front.sv
rtl/core/cs_back.sv
rtl/core/cosine_similarity.sv
tb/tb.sv
